@@ design/itoa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for integer_to_ascii_radix
// Format codes, field widths and the digit-to-ASCII lookup.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int VALUE_W   = 33;  // input integer width
	localparam int CHAR_W    = 7;   // ASCII code width
	localparam int WORK_W    = 44;  // widest hex pattern held in the work register
	localparam int MAX_CHARS = 11;
	localparam int CNT_W     = 4;   // holds 0..MAX_CHARS-1

	typedef enum logic [1:0] {
		FMT_DEC   = 2'd0,
		FMT_HEX_L = 2'd1,
		FMT_HEX_U = 2'd2,
		FMT_NONE  = 2'd3
	} fmt_t;

	localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;  // '-'
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;  // '0'
	localparam logic [CHAR_W-1:0] CH_LOW_A = 7'd97;  // 'a'
	localparam logic [CHAR_W-1:0] CH_UP_A  = 7'd65;  // 'A'

	// floor(x/5) = (x * RECIP_5) >> 34 for any 32-bit x
	localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] base;
		begin
			if (d < 4'd10) begin
				digit_char = CH_ZERO + CHAR_W'(d);
			end else begin
				base = upper ? CH_UP_A : CH_LOW_A;
				digit_char = base + CHAR_W'(d - 4'd10);
			end
		end
	endfunction

endpackage
`default_nettype wire

@@ design/integer_to_ascii_radix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: integer to ASCII text, decimal or hexadecimal
// Emits the characters of one number per item, most significant digit first.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_stall  | value[32:0] signed, func[1:0]
//  output  | out_valid / out_stall| char_code[6:0], last
//
//  One shared radix-step unit (divide by 10 via reciprocal multiply, or a
//  4-bit shift for hex) produces one digit per cycle into a small buffer;
//  the digits then leave one per cycle through the output register unless out_stall holds it.
//  func = 3 is accepted and yields nothing. arst_n clears the control state.
//  A stalled output holds; input is taken again once the last char is loaded.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [itoa_pkg::VALUE_W-1:0] value,
	input  wire logic [1:0]                      func,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [itoa_pkg::CHAR_W-1:0]          char_code,
	output logic                                 last
);
	import itoa_pkg::*;

	localparam int HEX_W = (VALUE_BITS > WORK_W) ? WORK_W : ((VALUE_BITS < 4) ? 4 : VALUE_BITS);
	localparam logic [WORK_W-1:0] HEX_MASK = WORK_W'((65'd1 << HEX_W) - 65'd1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [WORK_W-1:0]   work_q;
	logic                dec_q;
	logic                upper_q;
	logic                neg_q;
	logic                sign_pend_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    rd_q;
	logic [3:0]          dig_q [MAX_CHARS];
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	logic                in_acc;
	logic                out_free;
	logic                emit_ld;
	fmt_t                fmt;
	logic [VALUE_W-1:0]  mag;
	logic [WORK_W-1:0]   pattern;
	logic [WORK_W-1:0]   load_val;
	logic [31:0]         half;
	logic [63:0]         prod;
	logic [29:0]         dec_quot;
	logic [3:0]          qt4;
	logic [WORK_W-1:0]   step_q;
	logic [3:0]          step_r;
	logic                conv_done;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_ld   = (state_q == ST_EMIT) && out_free;
	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	always_comb begin
		fmt      = fmt_t'(func);
		mag      = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
		pattern  = {{(WORK_W-VALUE_W){value[VALUE_W-1]}}, value} & HEX_MASK;
		load_val = (fmt == FMT_DEC) ? WORK_W'(mag) : pattern;
	end

	// shared radix step: quotient and remainder of work_q by 10 or 16
	always_comb begin
		half     = work_q[32:1];
		prod     = {32'd0, half} * {32'd0, RECIP_5};
		dec_quot = prod[63:34];
		// low bits of 10*q; the remainder is below 10, so four bits suffice
		qt4      = {dec_quot[0], 3'b000} + {dec_quot[2:0], 1'b0};
		if (dec_q) begin
			step_q = WORK_W'(dec_quot);
			step_r = work_q[3:0] - qt4;
		end else begin
			step_q = {4'b0000, work_q[WORK_W-1:4]};
			step_r = work_q[3:0];
		end
		conv_done = (step_q == '0) || (cnt_q == CNT_W'(MAX_CHARS - 1));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CONV) begin
			dig_q[cnt_q] <= step_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			work_q      <= '0;
			dec_q       <= 1'b0;
			upper_q     <= 1'b0;
			neg_q       <= 1'b0;
			sign_pend_q <= 1'b0;
			cnt_q       <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && fmt != FMT_NONE) begin
						work_q  <= load_val;
						dec_q   <= (fmt == FMT_DEC);
						upper_q <= (fmt == FMT_HEX_U);
						neg_q   <= (fmt == FMT_DEC) && value[VALUE_W-1];
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					work_q <= step_q;
					cnt_q  <= cnt_q + CNT_W'(1);
					if (conv_done) begin
						rd_q        <= cnt_q;
						sign_pend_q <= neg_q;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (sign_pend_q) begin
							char_q      <= CH_MINUS;
							last_q      <= 1'b0;
							sign_pend_q <= 1'b0;
						end else begin
							char_q <= digit_char(dig_q[rd_q], upper_q);
							last_q <= (rd_q == '0);
							if (rd_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								rd_q <= rd_q - CNT_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for integer_to_ascii_radix
// Drives numbers in all three formats and the unused one, predicts the text of
// each one, and checks every character and its last flag in arrival order.
// The sender idles and the receiver stalls at random. One long receiver hold-off backs up
// the block.
// ----------------------------------------------------------------------------
module tb;
	import itoa_pkg::*;

	localparam int VALUE_BITS = 32;
	localparam int HEX_BITS   = VALUE_BITS > 44 ? 44 : (VALUE_BITS < 4 ? 4 : VALUE_BITS);
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 30;

	typedef logic signed [VALUE_W-1:0] num_t;
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	num_t              value;
	logic [1:0]        func;
	logic              out_valid;
	logic              out_stall;
	logic [CHAR_W-1:0] char_code;
	logic              last;

	text_char_t expected_text[$];
	text_char_t want;
	int         mismatch_count = 0;
	int         idle_pct  = 24;
	int         stall_pct = 24;
	bit         hold_req  = 1'b0;

	integer_to_ascii_radix #(.VALUE_BITS(VALUE_BITS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value(value), .func(func),
		.out_valid(out_valid), .out_stall(out_stall), .char_code(char_code), .last(last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CHAR_W-1:0] ascii_digit(input logic [3:0] d, input logic upper);
		if (d < 4'd10) begin
			return 7'd48 + 7'(d);
		end
		return (upper ? 7'd65 : 7'd97) + 7'(d) - 7'd10;
	endfunction

	// expected characters of one number, appended to expected_text
	function automatic void predict_text(input num_t v, input logic [1:0] f);
		logic signed [63:0] wide;
		logic [63:0]        mag;
		logic [63:0]        radix;
		logic [CHAR_W-1:0]  rev[MAX_CHARS];
		logic [CHAR_W-1:0]  text[$];
		logic               neg;
		int                 n;
		wide = v;
		neg = 1'b0;
		n = 0;
		if (f == FMT_NONE) begin
			return;
		end
		if (f == FMT_DEC) begin
			neg = wide < 0;
			mag = neg ? 64'(-wide) : 64'(wide);
			radix = 64'd10;
		end else begin
			mag = 64'(wide) & ((64'd1 << HEX_BITS) - 64'd1);
			radix = 64'd16;
		end
		do begin
			rev[n] = ascii_digit(4'(mag % radix), f == FMT_HEX_U);
			mag = mag / radix;
			n++;
		end while (mag != 0 && n < MAX_CHARS);
		if (neg) begin
			text.push_back(CH_MINUS);
		end
		while (n > 0 && text.size() < MAX_CHARS) begin
			n--;
			text.push_back(rev[n]);
		end
		foreach (text[k]) begin
			expected_text.push_back('{code: text[k], last: k == text.size() - 1});
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatch_count++;
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input num_t v, input logic [1:0] f);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		func     <= f;
		do @(posedge clk); while (in_stall);
		predict_text(v, f);
		@(negedge clk);
	endtask

	function automatic num_t random_number();
		logic [31:0] w;
		num_t        r;
		int          n;
		w = $urandom;
		case ($urandom_range(3))
			0: begin
				r = {1'($urandom_range(1)), w};
			end
			1: begin
				r = 33'($urandom_range(0, 40));
				r = r - 33'sd20;
			end
			2: begin
				r = {w[31], w};
			end
			default: begin
				n = $urandom_range(9);
				r = 33'sd1;
				repeat (n) r = r * 33'sd10;
				if ($urandom_range(1)) r = r - 33'sd1;
				if ($urandom_range(1)) r = -r;
			end
		endcase
		return r;
	endfunction

	function automatic logic [1:0] random_format();
		int r;
		r = $urandom_range(99);
		if (r < 40) return FMT_DEC;
		if (r < 65) return FMT_HEX_L;
		if (r < 90) return FMT_HEX_U;
		return FMT_NONE;
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("char %0d with nothing expected", char_code));
			end else begin
				want = expected_text.pop_front();
				if (char_code !== want.code)
					report_mismatch($sformatf("char_code %0d, want %0d", char_code, want.code));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b (char %0d)", last, want.last,
						want.code));
			end
		end
	end

	task automatic test_directed();
		send_item(33'sd0, FMT_DEC);
		send_item(33'sd0, FMT_HEX_L);
		send_item(33'sd0, FMT_HEX_U);
		send_item(33'sd1, FMT_DEC);
		send_item(-33'sd1, FMT_DEC);
		send_item(-33'sd1, FMT_HEX_L);
		send_item(-33'sd1, FMT_HEX_U);
		send_item(33'sd9, FMT_DEC);
		send_item(33'sd10, FMT_DEC);
		send_item(33'sd999999999, FMT_DEC);
		send_item(33'sd1000000000, FMT_DEC);
		send_item(33'sd2147483647, FMT_DEC);
		send_item(-33'sd2147483648, FMT_DEC);
		send_item(-33'sd2147483648, FMT_HEX_U);
		send_item(33'sd4294967295, FMT_DEC);
		send_item(33'sd4294967295, FMT_HEX_L);
		send_item({1'b1, 32'h0}, FMT_DEC);     // most negative 33-bit value
		send_item({1'b1, 32'h0}, FMT_HEX_L);   // low 32 bits are all zero
		send_item({1'b1, 32'h1}, FMT_HEX_U);
		send_item(33'sh0ABCDEF12, FMT_HEX_L);
		send_item(33'sh0ABCDEF12, FMT_HEX_U);
		send_item(33'sh00000000F, FMT_HEX_U);
		send_item(33'sd12345, FMT_NONE);
		send_item(-33'sd1, FMT_NONE);
		send_item(33'sd7, FMT_DEC);            // right after unused format
	endtask

	task automatic test_random(input int count);
		repeat (count) send_item(random_number(), random_format());
	endtask

	task automatic test_back_to_back();
		idle_pct = 0;
		stall_pct = 0;
		test_random(30);
		idle_pct = 24;
		stall_pct = 24;
	endtask

	task automatic test_backpressure();
		num_t v;
		idle_pct = 0;
		hold_req = 1'b1;
		repeat (16) begin
			v = {1'b0, 32'($urandom_range(32'hFFFF_FFFF, 32'd1000000000))};
			send_item($urandom_range(1) ? v : -v, random_format());
		end
		idle_pct = 24;
	endtask

	task automatic drain_and_finish();
		in_valid <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		value    = '0;
		func     = FMT_DEC;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(20);
		test_back_to_back();
		test_backpressure();
		test_random(20);
		drain_and_finish();
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
